// ----- rtl/png_row_unfilter_top_macros.svh -----
// Assertion macros for the PNG row unfilter.
// Depends on signals named clk and arst_n in the module that includes it.
`ifndef PNG_ROW_UNFILTER_TOP_MACROS_SVH
`define PNG_ROW_UNFILTER_TOP_MACROS_SVH

// Condition now implies consequence in the same cycle.
`define PRU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Condition now implies consequence in the next cycle.
`define PRU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/pru_pkg.sv -----
// Shared constants, codes and the Paeth predictor for the PNG row unfilter.
// No dependencies.
package pru_pkg;

	localparam int MAX_ROW_BYTES = 16384;

	localparam int ROW_LEN_W  = 15;
	localparam int PIX_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 15;
	localparam int FILT_W     = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 1'b1;

	// Filter kinds; raw marks an unknown filter type
	localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
	localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
	localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
	localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
	localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;
	localparam logic [FILT_W-1:0] FILT_RAW   = 3'd5;

	localparam logic [7:0] FILT_MAX_CODE = 8'd4;

	function automatic logic [9:0] abs10(logic signed [9:0] v);
		return (v < 0) ? 10'(-v) : 10'(v);
	endfunction

	// Paeth: pick the neighbor closest to left + up - upleft, ties to left, then up
	function automatic logic [7:0] paeth(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		pa = abs10($signed({2'b00, b}) - $signed({2'b00, c}));
		pb = abs10($signed({2'b00, a}) - $signed({2'b00, c}));
		pc = abs10($signed({2'b00, a}) + $signed({2'b00, b})
			- $signed({1'b0, c, 1'b0}));
		if (pa <= pb && pa <= pc)
			return a;
		else if (pb <= pc)
			return b;
		else
			return c;
	endfunction

endpackage

// ----- rtl/pru_if.sv -----
// Valid/ready channel interfaces of the PNG row unfilter: stream in, results out,
// configuration writes. Depends on pru_pkg.
interface pru_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_image;

	modport source (output valid, data_byte, first_of_image, input ready);
	modport sink   (input valid, data_byte, first_of_image, output ready);
endinterface

interface pru_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       end_of_row;
	logic       bad_filter;

	modport source (output valid, pixel_byte, end_of_row, bad_filter, input ready);
	modport sink   (input valid, pixel_byte, end_of_row, bad_filter, output ready);
endinterface

interface pru_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pru_pkg::CFG_IDX_W-1:0]    addr;
	logic [pru_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

// ----- rtl/pru_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- rtl/png_row_unfilter_top.sv -----
// PNG row unfilter: takes the inflated stream one byte per transfer and returns one
// reconstructed byte per data byte (none for the filter-type byte that opens each row).
// Sustains one byte per clock while the result side does not stall; a byte's result
// is valid after the stage 1 register and the output register. The previous row
// lives in a single-port-read, single-port-write RAM of MAX_ROW_BYTES bytes; its
// address is issued in the cycle the byte is accepted and the registered read data
// is used in stage 1, where the byte is reconstructed and written back in
// place. The store is never cleared: rows longer than any earlier row of the image read
// stale data, so begin every image with first_of_image on its first filter byte.
// row_length and pixel_bytes are taken through the configuration channel, always ready,
// and must be written only while no byte is in flight. Unknown filter types (above 4)
// set bad_filter for the rest of the image and pass the row through unchanged.
// Depends on pru_pkg, pru_if.sv, pru_ram.sv and png_row_unfilter_top_macros.svh.
`include "png_row_unfilter_top_macros.svh"

module png_row_unfilter_top #(
	parameter int MAX_ROW_BYTES = pru_pkg::MAX_ROW_BYTES
) (
	input  logic          clk,
	input  logic          arst_n,
	pru_in_if.sink        stream,
	pru_out_if.source     result,
	pru_cfg_if.sink       cfg
);

	localparam int AW = $clog2(MAX_ROW_BYTES);
	localparam int CW = $clog2(MAX_ROW_BYTES + 1);
	localparam int LW = (CW > pru_pkg::ROW_LEN_W) ? CW : pru_pkg::ROW_LEN_W;

	// ---------------- configuration ----------------
	logic [pru_pkg::ROW_LEN_W-1:0] row_length_q;
	logic [pru_pkg::PIX_W-1:0]     pixel_bytes_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q  <= pru_pkg::ROW_LEN_W'(1);
			pixel_bytes_q <= pru_pkg::PIX_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				pru_pkg::CFG_ROW_LENGTH:  row_length_q  <= cfg.data;
				pru_pkg::CFG_PIXEL_BYTES: pixel_bytes_q <= cfg.data[pru_pkg::PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp row length into 1..MAX_ROW_BYTES
	logic [LW-1:0] len_eff;
	always_comb begin
		if (row_length_q == '0)
			len_eff = LW'(1);
		else if (LW'(row_length_q) > LW'(MAX_ROW_BYTES))
			len_eff = LW'(MAX_ROW_BYTES);
		else
			len_eff = LW'(row_length_q);
	end

	// ---------------- stage 0: accept, column tracking, row-store read ----------------
	logic          s1_valid_q;
	logic          s1_adv;
	logic          out_valid_q;
	logic          accept;
	logic [CW-1:0] col_q;     // 0 = filter byte expected, k = next data byte is x = k-1
	logic [1:0]    mod3_q;    // (col_q - 1) mod 3 while in a row
	logic [CW-1:0] col_m1;
	logic [AW-1:0] x_addr;
	logic          at_filter;
	logic          is_last;
	logic [1:0]    lane;

	assign s1_adv       = s1_valid_q && (!out_valid_q || result.ready);
	assign stream.ready = !s1_valid_q || s1_adv;
	assign accept       = stream.valid && stream.ready;

	assign at_filter = (col_q == '0);
	assign col_m1    = col_q - CW'(1);
	assign x_addr    = col_m1[AW-1:0];
	assign is_last   = (LW'(col_q) >= len_eff);

	// Byte lane within the pixel: x mod pixel_bytes, out-of-range counts clamped
	always_comb begin
		case (pixel_bytes_q) inside
			3'd0, 3'd1: lane = 2'd0;
			3'd2:       lane = {1'b0, x_addr[0]};
			3'd3:       lane = mod3_q;
			default:    lane = x_addr[1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			mod3_q <= 2'd0;
		end else if (accept) begin
			if (at_filter) begin
				col_q  <= CW'(1);
				mod3_q <= 2'd0;
			end else if (is_last) begin
				col_q  <= '0;
			end else begin
				col_q  <= col_q + CW'(1);
				mod3_q <= (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
			end
		end
	end

	// ---------------- row store ----------------
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	pru_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROW_BYTES)
	) u_row_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (x_addr),
		.rdata (ram_rdata)
	);

	// ---------------- stage 1 registers ----------------
	logic          filter_s1;
	logic [7:0]    byte_s1;
	logic          start_s1;
	logic          last_s1;
	logic [1:0]    lane_s1;
	logic [AW-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (stream.ready)
			s1_valid_q <= stream.valid;
	end

	// Payload: advance with every accepted byte, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			filter_s1 <= at_filter;
			byte_s1   <= stream.data_byte;
			start_s1  <= stream.first_of_image;
			last_s1   <= is_last;
			lane_s1   <= lane;
			addr_s1   <= x_addr;
		end
	end

	// ---------------- stage 1: reconstruct ----------------
	logic [pru_pkg::FILT_W-1:0] filt_q;
	logic                       first_row_q;
	logic                       err_q;
	logic [7:0]                 left_q   [4];
	logic [7:0]                 upleft_q [4];

	logic [7:0] left_v;
	logic [7:0] upleft_v;
	logic [7:0] up_v;
	logic [8:0] avg_sum;
	logic [7:0] pred;
	logic [7:0] value;
	logic       data_adv;
	logic       filt_adv;
	logic       bad_code;

	assign left_v   = left_q[lane_s1];
	assign upleft_v = upleft_q[lane_s1];
	assign up_v     = first_row_q ? 8'd0 : ram_rdata;
	assign avg_sum  = {1'b0, left_v} + {1'b0, up_v};

	always_comb begin
		case (filt_q)
			pru_pkg::FILT_SUB:   pred = left_v;
			pru_pkg::FILT_UP:    pred = up_v;
			pru_pkg::FILT_AVG:   pred = avg_sum[8:1];
			pru_pkg::FILT_PAETH: pred = pru_pkg::paeth(left_v, up_v, upleft_v);
			default:             pred = 8'd0;
		endcase
	end

	assign value    = byte_s1 + pred;
	assign data_adv = s1_adv && !filter_s1;
	assign filt_adv = s1_adv && filter_s1;
	assign bad_code = (byte_s1 > pru_pkg::FILT_MAX_CODE);

	// Write the reconstructed byte back as next row's "up"
	assign ram_we    = data_adv;
	assign ram_waddr = addr_s1;
	assign ram_wdata = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q      <= pru_pkg::FILT_NONE;
			first_row_q <= 1'b1;
			err_q       <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else if (filt_adv) begin
			// Filter byte: pick the row's filter, clear neighbor lanes
			filt_q <= bad_code ? pru_pkg::FILT_RAW : byte_s1[pru_pkg::FILT_W-1:0];
			if (start_s1)
				first_row_q <= 1'b1;
			err_q <= (err_q && !start_s1) || bad_code;
			for (int i = 0; i < 4; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else if (data_adv) begin
			left_q[lane_s1]   <= value;
			upleft_q[lane_s1] <= up_v;
			if (last_s1)
				first_row_q <= 1'b0;
		end
	end

	// ---------------- output register ----------------
	logic [7:0] pix_q;
	logic       eor_q;
	logic       bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (data_adv)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (data_adv) begin
			pix_q <= value;
			eor_q <= last_s1;
			bad_q <= err_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.pixel_byte = pix_q;
	assign result.end_of_row = eor_q;
	assign result.bad_filter = bad_q;

	// ---------------- assertions ----------------
	// A stalled stage 1 must block the input so the row-store read data holds
	`PRU_ASSERT_NOW(a_stall_hold, s1_valid_q && !s1_adv, !accept, "byte accepted under stall")
	// A filter byte always opens the row at the first data column
	`PRU_ASSERT_NEXT(a_col_open, accept && at_filter, col_q == CW'(1), "column did not open after filter byte")
	// An image start with a known filter clears the error latch
	`PRU_ASSERT_NEXT(a_err_clear, filt_adv && start_s1 && !bad_code, !err_q, "error latch not cleared at image start")

endmodule
